// ===== hw/rtl/ica_pkg.sv =====
`timescale 1ns / 1ps
// Package with widths, codes, types and helper functions of the integer calculator ALU.
package ica_pkg;

    localparam int DW     = 32;
    localparam int HALF_W = DW / 2;
    localparam int RES_W  = 32;
    localparam int ROOT_W = 16;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int CNT_W  = $clog2(DW + 1);

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_POW  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM  = 3'd5;
    localparam logic [OP_W-1:0] OP_SQRT = 3'd6;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd1;
    localparam logic [ST_W-1:0] ST_NEGROOT  = 3'd2;
    localparam logic [ST_W-1:0] ST_SATURATE = 3'd3;
    localparam logic [ST_W-1:0] ST_BADOP    = 3'd4;

    localparam logic [DW-1:0] SIGN_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] SIGN_MAX = ~SIGN_MIN;
    localparam logic [DW-1:0] ROOT_TOP = {2'b01, {(DW-2){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_DIV,
        S_DIV_FIX,
        S_POW_MUL,
        S_POW_CHK,
        S_SQRT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic          sub;
        logic [DW:0]   x;
        logic [DW:0]   y;
        logic [DW-1:0] mx;
        logic [DW-1:0] my;
    } unit_req_t;

    typedef struct packed {
        logic [DW:0]     diff;
        logic            ge;
        logic [2*DW-1:0] prod;
    } unit_rsp_t;

    function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DW-1:0] apply_sign(input logic [DW-1:0] mag, input logic neg);
        return neg ? (~mag + 1'b1) : mag;
    endfunction

endpackage

// ===== hw/rtl/ica_unit.sv =====
`timescale 1ns / 1ps
// Shared arithmetic unit: one add/subtract with compare and one unsigned multiplier.
module ica_unit (
    input  ica_pkg::unit_req_t req,
    output ica_pkg::unit_rsp_t rsp
);
    import ica_pkg::*;

    logic [DW+1:0]   xe;
    logic [DW+1:0]   ye;
    logic [DW+1:0]   sum;

    always_comb
    begin
        xe  = {1'b0, req.x};
        ye  = req.sub ? ~{1'b0, req.y} : {1'b0, req.y};
        sum = xe + ye + (DW+2)'(req.sub);
        rsp.diff = sum[DW:0];
        rsp.ge   = ~sum[DW+1];
        rsp.prod = {{DW{1'b0}}, req.mx} * {{DW{1'b0}}, req.my};
    end

endmodule

// ===== hw/rtl/integer_calculator_alu.sv =====
`timescale 1ns / 1ps
// Top level of the integer calculator ALU with its operation sequencer.
// One beat is taken at a time; in_ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next beat is taken. The arithmetic
// runs through a shared add/subtract unit and a shared 32x32 multiplier.
// From an accepted beat, add and subtract go from the start state to the output state;
// multiply adds a product state; divide and remainder step the divide state (one quotient
// bit per cycle), then a sign-fix state; square roots step the root state (one root bit per
// cycle for each operand); power alternates a multiply and a check state (at most 32
// multiplies before the saturation check stops the loop). Divide by zero, unknown opcodes
// and power cases with no multiply go straight to the output state, which waits on out_ready.
module integer_calculator_alu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ica_pkg::OP_W-1:0]    op,
    input  logic signed [31:0]          operand_a,
    input  logic signed [31:0]          operand_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          result,
    output logic [ica_pkg::ROOT_W-1:0]  second_root,
    output logic [ica_pkg::ST_W-1:0]    status
);
    import ica_pkg::*;

    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [DW-1:0]       a_reg, a_next;
    logic [DW-1:0]       b_reg, b_next;
    logic [DW-1:0]       acc_reg, acc_next;
    logic [DW-1:0]       q_reg, q_next;
    logic [DW-1:0]       bit_reg, bit_next;
    logic [DW-1:0]       mag_reg, mag_next;
    logic [2*DW-1:0]     prod_reg, prod_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic                phase_reg, phase_next;
    logic [DW-1:0]       res_reg, res_next;
    logic [HALF_W-1:0]   root2_reg, root2_next;
    logic [ST_W-1:0]     st_reg, st_next;

    logic [RES_W-1:0]    out_res_reg, out_res_next;
    logic [ROOT_W-1:0]   out_root_reg, out_root_next;
    logic [ST_W-1:0]     out_st_reg, out_st_next;

    unit_req_t           req;
    unit_rsp_t           rsp;

    ica_unit u_unit (
        .req (req),
        .rsp (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        q_reg        <= q_next;
        bit_reg      <= bit_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        phase_reg    <= phase_next;
        res_reg      <= res_next;
        root2_reg    <= root2_next;
        st_reg       <= st_next;
        out_res_reg  <= out_res_next;
        out_root_reg <= out_root_next;
        out_st_reg   <= out_st_next;
    end

    always_comb
    begin
        logic [DW-1:0] ma_v;
        logic          rneg_v;
        logic [DW:0]   t_v;
        logic [DW-1:0] qn_v;
        logic [DW-1:0] lim_v;

        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        root2_next     = root2_reg;
        st_next        = st_reg;
        out_res_next   = out_res_reg;
        out_root_next  = out_root_reg;
        out_st_next    = out_st_reg;
        in_ready       = 1'b0;
        req            = '0;
        ma_v           = magnitude(a_reg);
        rneg_v         = a_reg[DW-1] & b_reg[0];
        t_v            = {acc_reg, q_reg[DW-1]};
        qn_v           = q_reg >> 1;
        lim_v          = neg_reg ? SIGN_MIN : SIGN_MAX;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = op;
                    a_next     = DW'(operand_a);
                    b_next     = DW'(operand_b);
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_next   = '0;
                root2_next = '0;
                st_next    = ST_OK;
                state_next = S_OUT;
                unique case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        req.sub  = (op_reg == OP_SUB);
                        req.x    = {1'b0, a_reg};
                        req.y    = {1'b0, b_reg};
                        res_next = rsp.diff[DW-1:0];
                    end
                    OP_MUL:
                    begin
                        req.mx     = a_reg;
                        req.my     = b_reg;
                        prod_next  = rsp.prod;
                        state_next = S_MUL;
                    end
                    OP_DIV, OP_REM:
                    begin
                        if (b_reg == '0)
                        begin
                            st_next = ST_DIVZERO;
                        end
                        else
                        begin
                            mag_next   = magnitude(b_reg);
                            q_next     = ma_v;
                            acc_next   = '0;
                            cnt_next   = '0;
                            neg_next   = (op_reg == OP_DIV) ? (a_reg[DW-1] ^ b_reg[DW-1])
                                                            : a_reg[DW-1];
                            state_next = S_DIV;
                        end
                    end
                    OP_POW:
                    begin
                        if (b_reg[DW-1])
                        begin
                            if (ma_v == '0)
                                st_next = ST_DIVZERO;
                            else if (ma_v == DW'(1))
                                res_next = apply_sign(DW'(1), rneg_v);
                        end
                        else if (b_reg == '0)
                        begin
                            res_next = DW'(1);
                        end
                        else if (ma_v <= DW'(1))
                        begin
                            res_next = apply_sign(ma_v, rneg_v);
                        end
                        else
                        begin
                            mag_next   = ma_v;
                            acc_next   = DW'(1);
                            cnt_next   = '0;
                            neg_next   = rneg_v;
                            state_next = S_POW_MUL;
                        end
                    end
                    OP_SQRT:
                    begin
                        if (a_reg[DW-1] || b_reg[DW-1])
                            st_next = ST_NEGROOT;
                        acc_next   = a_reg[DW-1] ? '0 : a_reg;
                        q_next     = '0;
                        bit_next   = ROOT_TOP;
                        cnt_next   = '0;
                        phase_next = 1'b0;
                        state_next = S_SQRT;
                    end
                    default:
                    begin
                        st_next = ST_BADOP;
                    end
                endcase
            end

            S_MUL:
            begin
                res_next   = prod_reg[DW-1:0];
                state_next = S_OUT;
            end

            S_DIV:
            begin
                req.sub = 1'b1;
                req.x   = t_v;
                req.y   = {1'b0, mag_reg};
                if (rsp.ge)
                begin
                    acc_next = rsp.diff[DW-1:0];
                    q_next   = {q_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    acc_next = t_v[DW-1:0];
                    q_next   = {q_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DW - 1))
                    state_next = S_DIV_FIX;
            end

            S_DIV_FIX:
            begin
                res_next   = apply_sign((op_reg == OP_DIV) ? q_reg : acc_reg, neg_reg);
                state_next = S_OUT;
            end

            S_POW_MUL:
            begin
                if (DW'(cnt_reg) == b_reg)
                begin
                    res_next   = apply_sign(acc_reg, neg_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    req.mx     = acc_reg;
                    req.my     = mag_reg;
                    prod_next  = rsp.prod;
                    state_next = S_POW_CHK;
                end
            end

            S_POW_CHK:
            begin
                if (prod_reg > {{DW{1'b0}}, lim_v})
                begin
                    st_next    = ST_SATURATE;
                    res_next   = lim_v;
                    state_next = S_OUT;
                end
                else
                begin
                    acc_next   = prod_reg[DW-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_POW_MUL;
                end
            end

            S_SQRT:
            begin
                req.sub = 1'b1;
                req.x   = {1'b0, acc_reg};
                req.y   = {1'b0, q_reg | bit_reg};
                if (rsp.ge)
                begin
                    acc_next = rsp.diff[DW-1:0];
                    qn_v     = (q_reg >> 1) | bit_reg;
                end
                q_next   = qn_v;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HALF_W - 1))
                begin
                    if (!phase_reg)
                    begin
                        res_next   = qn_v;
                        acc_next   = b_reg[DW-1] ? '0 : b_reg;
                        q_next     = '0;
                        bit_next   = ROOT_TOP;
                        cnt_next   = '0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        root2_next = qn_v[HALF_W-1:0];
                        state_next = S_OUT;
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_res_next   = RES_W'($signed(res_reg));
                    out_root_next  = ROOT_W'(root2_reg);
                    out_st_next    = st_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign result      = out_res_reg;
    assign second_root = out_root_reg;
    assign status      = out_st_reg;

endmodule
